[sv/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and font tables for the scan display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_CHARS     = 3'd1,
    REQ_NUMBER    = 3'd2,
    REQ_SYMBOLS   = 3'd3,
    REQ_INDICATOR = 3'd4
  } ssd_req_e;

  localparam int unsigned DigitCount     = 4;
  localparam int unsigned IndicatorCount = 14;
  localparam logic [2:0]  LastRow        = 3'd6;
  localparam logic [15:0] NumberMax      = 16'd9999;

  // Reciprocal multipliers for the decimal split of values up to 9999
  localparam logic [14:0] RecipThousand  = 15'd16778;  // >> 24
  localparam logic [12:0] RecipHundred   = 13'd5243;   // >> 19
  localparam logic [12:0] RecipTen       = 13'd6554;   // >> 16

  typedef logic [6:0] seg_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [3:0][7:0]  chars;
    logic [15:0]      number;
    logic [7:0]       symbol;
    logic [7:0]       ind_idx;
    logic             ind_on;
  } ssd_req_t;

  typedef struct packed {
    logic [7:0] row_drive;
    logic [7:0] col_drive;
  } ssd_scan_t;

  function automatic seg_t decimal_font(input logic [3:0] digit);
    seg_t seg;
    case (digit)
      4'd0:    seg = 7'h7E;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h6D;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h17;
      4'd5:    seg = 7'h5B;
      4'd6:    seg = 7'h7B;
      4'd7:    seg = 7'h0E;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h5F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

  function automatic seg_t glyph_of(input logic [7:0] ch);
    seg_t seg;
    case (ch)
      "0", "O", "o": seg = 7'h7E;
      "1", "I", "i": seg = 7'h06;
      "2":           seg = 7'h6D;
      "3":           seg = 7'h4F;
      "4", "Y", "y": seg = 7'h17;
      "5", "S", "s": seg = 7'h5B;
      "6":           seg = 7'h7B;
      "7":           seg = 7'h0E;
      "8":           seg = 7'h7F;
      "9":           seg = 7'h5F;
      "A", "a":      seg = 7'h3F;
      "b":           seg = 7'h73;
      "c":           seg = 7'h61;
      "d":           seg = 7'h67;
      "E", "e":      seg = 7'h79;
      "F", "f":      seg = 7'h39;
      "G":           seg = 7'h7A;
      "H":           seg = 7'h37;
      "h":           seg = 7'h33;
      "J", "j":      seg = 7'h46;
      "L", "l":      seg = 7'h70;
      "n":           seg = 7'h23;
      "P", "p":      seg = 7'h3D;
      "Q", "q":      seg = 7'h7C;
      "r":           seg = 7'h21;
      "t":           seg = 7'h71;
      "u", "U":      seg = 7'h62;
      "(":           seg = 7'h78;
      ")":           seg = 7'h4E;
      "-":           seg = 7'h01;
      "?":           seg = 7'h2C;
      default:       seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

[sv/ssd_ifs.sv]
// ----------------------------------------------------------------------------
// ssd_ifs
// Valid/ready channels for display requests and scan drive results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  char_0;
  logic [7:0]  char_1;
  logic [7:0]  char_2;
  logic [7:0]  char_3;
  logic [15:0] number_value;
  logic [7:0]  symbol_mask;
  logic [7:0]  indicator_index;
  logic        indicator_on;

  modport source (
    output valid, req_type, char_0, char_1, char_2, char_3,
           number_value, symbol_mask, indicator_index, indicator_on,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_0, char_1, char_2, char_3,
           number_value, symbol_mask, indicator_index, indicator_on,
    output ready
  );
endinterface

interface ssd_drive_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_drive;
  logic [7:0] col_drive;

  modport source (output valid, row_drive, col_drive, input ready);
  modport sink   (input valid, row_drive, col_drive, output ready);
endinterface

`default_nettype wire

[sv/seven_segment_scan_driver_top.sv]
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_top
// Row-multiplexed driver for four 7-segment digits, symbols and indicators.
// ----------------------------------------------------------------------------
// Takes one request transaction per clock when not stalled. A request is
// captured in an input register; from there it is applied to the display
// contents and, for a tick, the active-low row strobe and column pattern of
// the current scan row (0 to 6) are loaded into the output register. Writes
// of characters, a number, the symbol mask or an indicator bit produce no
// result. Throughput is one transaction per cycle; the only stall is a tick
// that finds the output register still holding a result the sink has not
// taken, and writes behind it wait in turn. Unknown request kinds are
// consumed and ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_driver_top
  import ssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ssd_req_if.sink     req_i,
  ssd_drive_if.source drive_o
);

  // Input register
  logic      s1_valid_q;
  ssd_req_t  s1_req_q;
  logic      s1_is_tick;
  logic      s1_fire;

  // Output register
  logic      out_valid_q;
  ssd_scan_t out_q;
  logic      out_free;

  seg_t [3:0] segs;
  ssd_scan_t  scan;

  assign s1_is_tick = (s1_req_q.kind == REQ_TICK);
  assign out_free   = !out_valid_q || drive_o.ready;
  // Writes always advance; a tick needs room in the output register
  assign s1_fire    = s1_valid_q && (!s1_is_tick || out_free);
  assign req_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  // Payload: capture on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_req_q.kind     <= req_i.req_type;
      s1_req_q.chars[0] <= req_i.char_0;
      s1_req_q.chars[1] <= req_i.char_1;
      s1_req_q.chars[2] <= req_i.char_2;
      s1_req_q.chars[3] <= req_i.char_3;
      s1_req_q.number   <= req_i.number_value;
      s1_req_q.symbol   <= req_i.symbol_mask;
      s1_req_q.ind_idx  <= req_i.indicator_index;
      s1_req_q.ind_on   <= req_i.indicator_on;
    end
  end

  ssd_glyph_enc u_enc (
    .req_i  (s1_req_q),
    .segs_o (segs)
  );

  ssd_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .req_i  (s1_req_q),
    .segs_i (segs),
    .scan_o (scan)
  );

  // Hold the result until taken; load a new one when a tick advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_is_tick) begin
      out_valid_q <= 1'b1;
    end else if (drive_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_is_tick) begin
      out_q <= scan;
    end
  end

  assign drive_o.valid     = out_valid_q;
  assign drive_o.row_drive = out_q.row_drive;
  assign drive_o.col_drive = out_q.col_drive;

endmodule

`default_nettype wire

[sv/ssd_glyph_enc.sv]
// ----------------------------------------------------------------------------
// ssd_glyph_enc
// Turns a character or number write into four digit segment patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_glyph_enc
  import ssd_pkg::*;
(
  input  ssd_req_t   req_i,
  output seg_t [3:0] segs_o
);

  seg_t [3:0]  char_segs;
  seg_t [3:0]  num_segs;
  logic        ended;
  logic [13:0] n_sat;
  logic [28:0] p1000;
  logic [25:0] p100;
  logic [25:0] p10;
  logic [3:0]  q1000;
  logic [6:0]  q100;
  logic [9:0]  q10;
  logic [3:0]  d1, d2, d3;

  // Characters: blank everything from the first terminator on
  always_comb begin
    ended = 1'b0;
    for (int i = 0; i < DigitCount; i++) begin
      if (req_i.chars[i] == 8'd0) begin
        ended = 1'b1;
      end
      char_segs[i] = ended ? 7'h00 : glyph_of(req_i.chars[i]);
    end
  end

  // Number: saturate, then split into decimal digits by reciprocal multiply
  always_comb begin
    n_sat = (req_i.number > NumberMax) ? NumberMax[13:0] : req_i.number[13:0];
    p1000 = 29'(n_sat) * 29'(RecipThousand);
    p100  = 26'(n_sat) * 26'(RecipHundred);
    p10   = 26'(n_sat) * 26'(RecipTen);
    q1000 = p1000[27:24];
    q100  = p100[25:19];
    q10   = p10[25:16];
    d1    = 4'(q100 - 7'(q1000) * 7'd10);
    d2    = 4'(q10 - 10'(q100) * 10'd10);
    d3    = 4'(n_sat - 14'(q10) * 14'd10);
    num_segs[0] = decimal_font(q1000);
    num_segs[1] = decimal_font(d1);
    num_segs[2] = decimal_font(d2);
    num_segs[3] = decimal_font(d3);
  end

  assign segs_o = (req_i.kind == REQ_NUMBER) ? num_segs : char_segs;

endmodule

`default_nettype wire

[sv/ssd_state.sv]
// ----------------------------------------------------------------------------
// ssd_state
// Display contents and scan row; applies writes and forms the row drive.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_state
  import ssd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  ssd_req_t   req_i,
  input  seg_t [3:0] segs_i,
  output ssd_scan_t  scan_o
);

  seg_t [3:0]  digits_q, digits_d;
  logic [7:0]  symbol_q, symbol_d;
  logic [13:0] ind_q, ind_d;
  logic [2:0]  row_q, row_d;
  logic [7:0]  pattern;

  always_comb begin
    digits_d = digits_q;
    symbol_d = symbol_q;
    ind_d    = ind_q;
    row_d    = row_q;
    if (fire_i) begin
      case (ssd_req_e'(req_i.kind))
        REQ_TICK:      row_d = (row_q >= LastRow) ? 3'd0 : row_q + 3'd1;
        REQ_CHARS:     digits_d = segs_i;
        REQ_NUMBER:    digits_d = segs_i;
        REQ_SYMBOLS:   symbol_d = req_i.symbol;
        REQ_INDICATOR: begin
          if (req_i.ind_idx < 8'(IndicatorCount)) begin
            ind_d[req_i.ind_idx[3:0]] = req_i.ind_on;
          end
        end
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      symbol_q <= '0;
      ind_q    <= '0;
      row_q    <= '0;
    end else begin
      digits_q <= digits_d;
      symbol_q <= symbol_d;
      ind_q    <= ind_d;
      row_q    <= row_d;
    end
  end

  // Select the lit pattern of the current row
  always_comb begin
    case (row_q)
      3'd0:    pattern = {2'b00, ind_q[5:0]};
      3'd1:    pattern = ind_q[13:6];
      3'd2:    pattern = symbol_q;
      3'd3:    pattern = {1'b0, digits_q[0]};
      3'd4:    pattern = {1'b0, digits_q[1]};
      3'd5:    pattern = {1'b0, digits_q[2]};
      3'd6:    pattern = {1'b0, digits_q[3]};
      default: pattern = 8'h00;
    endcase
  end

  assign scan_o.row_drive = ~(8'd1 << row_q);
  assign scan_o.col_drive = ~pattern;

endmodule

`default_nettype wire
